// ===== design/tvcr_pkg.sv =====
`default_nettype none

package tvcr_pkg;

    localparam int GP_SLOTS = 4;
    localparam int SE_SLOTS = 2;
    localparam int GRADIENT_POINTS_DEF = 4;
    localparam int SLANT_ENTRIES_DEF = 2;
    localparam int NEIGHBORS = 8;
    localparam int CHANNELS = 3;
    localparam int NORM_Q_W = 17;
    localparam int NORM_D_W = 16;
    localparam int MIX_Q_W = 8;
    localparam int MIX_D_W = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int GP_W = 41;

    localparam logic [14:0] STEEP_MAX = 15'h7fff;
    localparam logic signed [15:0] HN_FLAT = -16'sd16384;
    localparam logic signed [15:0] HN_TOP = 16'sh7fff;
    localparam logic signed [15:0] HN_BOTTOM = -16'sh8000;
    localparam logic [18:0] HN_OFFSET = 19'd16384;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_HEIGHT = 3'd0,
        REG_MAX_HEIGHT = 3'd1,
        REG_GP0        = 3'd2,
        REG_GP1        = 3'd3,
        REG_GP2        = 3'd4,
        REG_GP3        = 3'd5,
        REG_SE0        = 3'd6,
        REG_SE1        = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_WHITE,
        MODE_HIGH,
        MODE_LOW,
        MODE_INTERP
    } mode_t;

    typedef logic [CHANNELS-1:0][7:0] rgb_t;

    localparam rgb_t RGB_WHITE = '1;

    typedef struct packed {
        logic signed [15:0] center_height;
        logic signed [15:0] north_west_height;
        logic signed [15:0] north_height;
        logic signed [15:0] north_east_height;
        logic signed [15:0] west_height;
        logic signed [15:0] east_height;
        logic signed [15:0] south_west_height;
        logic signed [15:0] south_height;
        logic signed [15:0] south_east_height;
        logic [7:0]         neighbor_inside;
    } vertex_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    typedef struct packed {
        logic               present;
        logic signed [15:0] height;
        rgb_t               rgb;
    } gpoint_t;

    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
        rgb_t        rgb;
        logic [7:0]  rate;
    } slant_t;

    typedef struct packed {
        rgb_t       rgb;
        logic [7:0] rate;
    } blend_t;

    typedef struct packed {
        blend_t slant;
        logic   neg;
        logic   ovf;
        logic   flat;
    } norm_side_t;

    typedef struct packed {
        blend_t slant;
        mode_t  mode;
        rgb_t   direct;
    } mix_side_t;

endpackage

`default_nettype wire

// ===== design/tvcr_div.sv =====
`default_nettype none

module tvcr_div #(
    parameter int Q_W    = tvcr_pkg::MIX_Q_W,
    parameter int D_W    = tvcr_pkg::MIX_D_W,
    parameter int LANES  = tvcr_pkg::CHANNELS,
    parameter int SIDE_W = 1
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         en,
    input  wire                         in_valid,
    input  wire  [LANES-1:0][D_W-1:0]   in_rem,
    input  wire  [LANES-1:0][Q_W-1:0]   in_bits,
    input  wire  [D_W-1:0]              in_div,
    input  wire  [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [LANES-1:0][Q_W-1:0]   out_quot,
    output logic [LANES-1:0]            out_rem_nz,
    output logic [SIDE_W-1:0]           out_side
);

    logic [Q_W-1:0]                 valid_reg;
    logic [LANES-1:0][D_W-1:0]      rem_reg   [Q_W];
    logic [LANES-1:0][D_W-1:0]      rem_next  [Q_W];
    logic [LANES-1:0][Q_W-1:0]      bits_reg  [Q_W];
    logic [LANES-1:0][Q_W-1:0]      bits_next [Q_W];
    logic [LANES-1:0][Q_W-1:0]      quot_reg  [Q_W];
    logic [LANES-1:0][Q_W-1:0]      quot_next [Q_W];
    logic [D_W-1:0]                 div_reg   [Q_W];
    logic [SIDE_W-1:0]              side_reg  [Q_W];

    logic [LANES-1:0][D_W-1:0]      st_rem  [Q_W];
    logic [LANES-1:0][Q_W-1:0]      st_bits [Q_W];
    logic [LANES-1:0][Q_W-1:0]      st_quot [Q_W];
    logic [D_W-1:0]                 st_div  [Q_W];
    logic [SIDE_W-1:0]              st_side [Q_W];

    assign st_rem[0]  = in_rem;
    assign st_bits[0] = in_bits;
    assign st_quot[0] = '0;
    assign st_div[0]  = in_div;
    assign st_side[0] = in_side;

    for (genvar s = 1; s < Q_W; s++)
    begin : g_link
        assign st_rem[s]  = rem_reg[s-1];
        assign st_bits[s] = bits_reg[s-1];
        assign st_quot[s] = quot_reg[s-1];
        assign st_div[s]  = div_reg[s-1];
        assign st_side[s] = side_reg[s-1];
    end

    // one quotient bit per stage, restoring
    always_comb
    begin
        logic [D_W:0] trial;
        logic [D_W:0] diff;
        for (int s = 0; s < Q_W; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial = {st_rem[s][l], st_bits[s][l][Q_W-1]};
                diff  = trial - {1'b0, st_div[s]};
                if (trial >= {1'b0, st_div[s]})
                begin
                    rem_next[s][l]  = diff[D_W-1:0];
                    quot_next[s][l] = {st_quot[s][l][Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[s][l]  = trial[D_W-1:0];
                    quot_next[s][l] = {st_quot[s][l][Q_W-2:0], 1'b0};
                end
                bits_next[s][l] = {st_bits[s][l][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[Q_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < Q_W; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                bits_reg[s] <= bits_next[s];
                quot_reg[s] <= quot_next[s];
                div_reg[s]  <= st_div[s];
                side_reg[s] <= st_side[s];
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_quot  = quot_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            out_rem_nz[l] = |rem_reg[Q_W-1][l];
        end
    end

endmodule

`default_nettype wire

// ===== design/tvcr_front.sv =====
`default_nettype none

module tvcr_front #(
    parameter int SLANT_ENTRIES = tvcr_pkg::SLANT_ENTRIES_DEF
) (
    input  wire                                       clk,
    input  wire                                       rst_n,
    input  wire                                       en,
    input  wire                                       in_valid,
    input  wire  tvcr_pkg::vertex_t                   vertex,
    input  wire  [15:0]                               min_height,
    input  wire  [15:0]                               max_height,
    input  wire  tvcr_pkg::slant_t [SLANT_ENTRIES-1:0] slants,
    output logic                                      out_valid,
    output logic [tvcr_pkg::NORM_D_W-1:0]             out_rem,
    output logic [tvcr_pkg::NORM_Q_W-1:0]             out_bits,
    output logic [tvcr_pkg::NORM_D_W-1:0]             out_div,
    output tvcr_pkg::norm_side_t                      out_side
);

    logic [15:0] nb [tvcr_pkg::NEIGHBORS];

    assign nb[0] = vertex.north_west_height;
    assign nb[1] = vertex.north_height;
    assign nb[2] = vertex.north_east_height;
    assign nb[3] = vertex.west_height;
    assign nb[4] = vertex.east_height;
    assign nb[5] = vertex.south_west_height;
    assign nb[6] = vertex.south_height;
    assign nb[7] = vertex.south_east_height;

    // stage 1: neighbor differences, height offsets
    logic        v1_reg;
    logic [15:0] absd_reg  [tvcr_pkg::NEIGHBORS];
    logic [15:0] absd_next [tvcr_pkg::NEIGHBORS];
    logic [16:0] asub_reg;
    logic [16:0] asub_next;
    logic [16:0] dsub_reg;
    logic [16:0] dsub_next;

    always_comb
    begin
        logic [16:0] diff;
        logic [16:0] mag;
        for (int i = 0; i < tvcr_pkg::NEIGHBORS; i++)
        begin
            diff = {vertex.center_height[15], vertex.center_height} - {nb[i][15], nb[i]};
            mag  = diff[16] ? (17'd0 - diff) : diff;
            absd_next[i] = vertex.neighbor_inside[i] ? mag[15:0] : 16'd0;
        end
        asub_next = {vertex.center_height[15], vertex.center_height}
                  - {min_height[15], min_height};
        dsub_next = {max_height[15], max_height} - {min_height[15], min_height};
    end

    // stage 2: steepness, sign folding
    logic        v2_reg;
    logic [14:0] steep_reg;
    logic [14:0] steep_next;
    logic        neg_reg;
    logic        neg_next;
    logic        flat_reg;
    logic        flat_next;
    logic [15:0] amag_reg;
    logic [15:0] amag_next;
    logic [15:0] dmag_reg;
    logic [15:0] dmag_next;

    always_comb
    begin
        logic [15:0] mx;
        logic [16:0] a2;
        logic [16:0] d2;
        mx = 16'd0;
        for (int i = 0; i < tvcr_pkg::NEIGHBORS; i++)
        begin
            if (absd_reg[i] > mx)
            begin
                mx = absd_reg[i];
            end
        end
        steep_next = mx[15] ? tvcr_pkg::STEEP_MAX : mx[14:0];
        a2 = dsub_reg[16] ? (17'd0 - asub_reg) : asub_reg;
        d2 = dsub_reg[16] ? (17'd0 - dsub_reg) : dsub_reg;
        neg_next  = a2[16];
        amag_next = a2[16] ? 16'(17'd0 - a2) : a2[15:0];
        dmag_next = d2[15:0];
        flat_next = (dsub_reg == 17'd0);
    end

    // stage 3: slant match, divider setup
    logic                 rem_next;
    tvcr_pkg::blend_t     slant_next;
    logic                 ovf_next;

    always_comb
    begin
        logic hit;
        hit = 1'b0;
        slant_next.rgb  = tvcr_pkg::RGB_WHITE;
        slant_next.rate = 8'd0;
        for (int i = 0; i < SLANT_ENTRIES; i++)
        begin
            if (!hit && slants[i].lo <= {1'b0, steep_reg}
                && {1'b0, steep_reg} <= slants[i].hi)
            begin
                hit        = 1'b1;
                slant_next = {slants[i].rgb, slants[i].rate};
            end
        end
        ovf_next = ({2'b00, amag_reg} >= {dmag_reg, 2'b00});
        rem_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            out_valid <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            absd_reg       <= absd_next;
            asub_reg       <= asub_next;
            dsub_reg       <= dsub_next;
            steep_reg      <= steep_next;
            neg_reg        <= neg_next;
            flat_reg       <= flat_next;
            amag_reg       <= amag_next;
            dmag_reg       <= dmag_next;
            out_rem        <= {2'b00, amag_reg[15:2]};
            out_bits       <= {amag_reg[1:0], {(tvcr_pkg::NORM_Q_W-2){rem_next}}};
            out_div        <= dmag_reg;
            out_side.slant <= slant_next;
            out_side.neg   <= neg_reg;
            out_side.ovf   <= ovf_next;
            out_side.flat  <= flat_reg;
        end
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !en |=> out_valid)
        else $error("front request dropped while held");

endmodule

`default_nettype wire

// ===== design/tvcr_ramp.sv =====
`default_nettype none

module tvcr_ramp #(
    parameter int GRADIENT_POINTS = tvcr_pkg::GRADIENT_POINTS_DEF
) (
    input  wire                                          clk,
    input  wire                                          rst_n,
    input  wire                                          en,
    input  wire                                          in_valid,
    input  wire  [tvcr_pkg::NORM_Q_W-1:0]                in_quot,
    input  wire                                          in_rem_nz,
    input  wire  tvcr_pkg::norm_side_t                   in_side,
    input  wire  tvcr_pkg::gpoint_t [GRADIENT_POINTS-1:0] points,
    output logic                                         out_valid,
    output logic [tvcr_pkg::CHANNELS-1:0][tvcr_pkg::MIX_D_W-1:0] out_rem,
    output logic [tvcr_pkg::CHANNELS-1:0][tvcr_pkg::MIX_Q_W-1:0] out_bits,
    output logic [tvcr_pkg::MIX_D_W-1:0]                 out_div,
    output tvcr_pkg::mix_side_t                          out_side
);

    localparam int CH = tvcr_pkg::CHANNELS;

    // stage 0: floor correction, offset, saturation
    logic                 v0_reg;
    logic signed [15:0]   hn0_reg;
    logic signed [15:0]   hn0_next;
    tvcr_pkg::blend_t     sl0_reg;

    always_comb
    begin
        logic [18:0]        qx;
        logic signed [18:0] hx;
        qx = {2'b00, in_quot};
        if (in_side.neg)
        begin
            qx = 19'd0 - (qx + {18'd0, in_rem_nz});
        end
        hx = $signed(qx - tvcr_pkg::HN_OFFSET);
        if (in_side.flat)
        begin
            hn0_next = tvcr_pkg::HN_FLAT;
        end
        else if (in_side.ovf)
        begin
            hn0_next = in_side.neg ? tvcr_pkg::HN_BOTTOM : tvcr_pkg::HN_TOP;
        end
        else if (hx > 19'sd32767)
        begin
            hn0_next = tvcr_pkg::HN_TOP;
        end
        else if (hx < -19'sd32768)
        begin
            hn0_next = tvcr_pkg::HN_BOTTOM;
        end
        else
        begin
            hn0_next = hx[15:0];
        end
    end

    // stage 1: nearest point above and below
    logic                 v1_reg;
    logic signed [15:0]   hn1_reg;
    logic                 fh_reg, fh_next;
    logic                 fl_reg, fl_next;
    logic signed [15:0]   hh_reg, hh_next;
    logic signed [15:0]   lh_reg, lh_next;
    tvcr_pkg::rgb_t       hc1_reg, hc1_next;
    tvcr_pkg::rgb_t       lc1_reg, lc1_next;
    tvcr_pkg::blend_t     sl1_reg;

    always_comb
    begin
        fh_next  = 1'b0;
        fl_next  = 1'b0;
        hh_next  = '0;
        lh_next  = '0;
        hc1_next = '0;
        lc1_next = '0;
        for (int i = 0; i < GRADIENT_POINTS; i++)
        begin
            if (points[i].present)
            begin
                if (hn0_reg < points[i].height && (!fh_next || hh_next > points[i].height))
                begin
                    fh_next  = 1'b1;
                    hh_next  = points[i].height;
                    hc1_next = points[i].rgb;
                end
                if (hn0_reg > points[i].height && (!fl_next || lh_next < points[i].height))
                begin
                    fl_next  = 1'b1;
                    lh_next  = points[i].height;
                    lc1_next = points[i].rgb;
                end
            end
        end
    end

    tvcr_pkg::mode_t mode1;

    always_comb
    begin
        unique case ({fh_reg, fl_reg})
            2'b11:   mode1 = tvcr_pkg::MODE_INTERP;
            2'b10:   mode1 = tvcr_pkg::MODE_HIGH;
            2'b01:   mode1 = tvcr_pkg::MODE_LOW;
            default: mode1 = tvcr_pkg::MODE_WHITE;
        endcase
    end

    // stage 2: span and offsets
    logic                 v2_reg;
    logic [15:0]          dd2_reg;
    logic [15:0]          n2_reg;
    logic [15:0]          m2_reg;
    logic [16:0]          dd_x;
    logic [16:0]          n_x;
    tvcr_pkg::mode_t      mode2_reg;
    tvcr_pkg::rgb_t       hc2_reg;
    tvcr_pkg::rgb_t       lc2_reg;
    tvcr_pkg::blend_t     sl2_reg;

    assign dd_x = {hh_reg[15], hh_reg} - {lh_reg[15], lh_reg};
    assign n_x  = {hn1_reg[15], hn1_reg} - {lh_reg[15], lh_reg};

    // stage 3: weighted products
    logic                         v3_reg;
    logic [CH-1:0][23:0]          plo_reg;
    logic [CH-1:0][23:0]          phi_reg;
    logic [15:0]                  dd3_reg;
    tvcr_pkg::mode_t              mode3_reg;
    tvcr_pkg::rgb_t               hc3_reg;
    tvcr_pkg::rgb_t               lc3_reg;
    tvcr_pkg::blend_t             sl3_reg;
    logic [CH-1:0][23:0]          plo_next;
    logic [CH-1:0][23:0]          phi_next;

    always_comb
    begin
        for (int k = 0; k < CH; k++)
        begin
            plo_next[k] = {16'd0, lc2_reg[k]} * {8'd0, m2_reg};
            phi_next[k] = {16'd0, hc2_reg[k]} * {8'd0, n2_reg};
        end
    end

    // stage 4: numerators, direct color
    logic [CH-1:0][23:0]  num;
    tvcr_pkg::rgb_t       direct4;

    always_comb
    begin
        for (int k = 0; k < CH; k++)
        begin
            num[k] = plo_reg[k] + phi_reg[k] + {9'd0, dd3_reg[15:1]};
        end
        case (mode3_reg)
            tvcr_pkg::MODE_HIGH: direct4 = hc3_reg;
            tvcr_pkg::MODE_LOW:  direct4 = lc3_reg;
            default:             direct4 = tvcr_pkg::RGB_WHITE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= in_valid;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            out_valid <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hn0_reg   <= hn0_next;
            sl0_reg   <= in_side.slant;
            hn1_reg   <= hn0_reg;
            fh_reg    <= fh_next;
            fl_reg    <= fl_next;
            hh_reg    <= hh_next;
            lh_reg    <= lh_next;
            hc1_reg   <= hc1_next;
            lc1_reg   <= lc1_next;
            sl1_reg   <= sl0_reg;
            dd2_reg   <= dd_x[15:0];
            n2_reg    <= n_x[15:0];
            m2_reg    <= dd_x[15:0] - n_x[15:0];
            mode2_reg <= mode1;
            hc2_reg   <= hc1_reg;
            lc2_reg   <= lc1_reg;
            sl2_reg   <= sl1_reg;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            dd3_reg   <= dd2_reg;
            mode3_reg <= mode2_reg;
            hc3_reg   <= hc2_reg;
            lc3_reg   <= lc2_reg;
            sl3_reg   <= sl2_reg;
            for (int k = 0; k < CH; k++)
            begin
                out_rem[k]  <= num[k][23:8];
                out_bits[k] <= num[k][7:0];
            end
            out_div         <= dd3_reg;
            out_side.slant  <= sl3_reg;
            out_side.mode   <= mode3_reg;
            out_side.direct <= direct4;
        end
    end

    a_above: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && fh_reg |-> hh_reg > hn1_reg)
        else $error("upper gradient point not above height");

    a_below: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && fl_reg |-> lh_reg < hn1_reg)
        else $error("lower gradient point not below height");

endmodule

`default_nettype wire

// ===== design/tvcr_blend.sv =====
`default_nettype none

module tvcr_blend (
    input  wire                                                  clk,
    input  wire                                                  rst_n,
    input  wire                                                  en,
    input  wire                                                  in_valid,
    input  wire  [tvcr_pkg::CHANNELS-1:0][tvcr_pkg::MIX_Q_W-1:0] in_quot,
    input  wire  tvcr_pkg::mix_side_t                            in_side,
    output logic                                                 out_valid,
    output tvcr_pkg::color_t                                     out_color
);

    localparam int CH = tvcr_pkg::CHANNELS;

    logic                  v1_reg;
    logic [CH-1:0][15:0]   pc_reg;
    logic [CH-1:0][15:0]   ps_reg;
    logic [CH-1:0][15:0]   pc_next;
    logic [CH-1:0][15:0]   ps_next;
    tvcr_pkg::rgb_t        base;
    logic [7:0]            inv_rate;

    always_comb
    begin
        base     = (in_side.mode == tvcr_pkg::MODE_INTERP) ? in_quot : in_side.direct;
        inv_rate = 8'd255 - in_side.slant.rate;
        for (int k = 0; k < CH; k++)
        begin
            pc_next[k] = {8'd0, base[k]} * {8'd0, inv_rate};
            ps_next[k] = {8'd0, in_side.slant.rgb[k]} * {8'd0, in_side.slant.rate};
        end
    end

    // divide by 255 with rounding term already added
    tvcr_pkg::rgb_t res;

    always_comb
    begin
        logic [16:0] x;
        logic [16:0] y;
        for (int k = 0; k < CH; k++)
        begin
            x = {1'b0, pc_reg[k]} + {1'b0, ps_reg[k]} + 17'd127;
            y = x + {8'd0, x[16:8]} + 17'd1;
            res[k] = y[15:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pc_reg          <= pc_next;
            ps_reg          <= ps_next;
            out_color.red   <= res[2];
            out_color.green <= res[1];
            out_color.blue  <= res[0];
        end
    end

endmodule

`default_nettype wire

// ===== design/terrain_vertex_color_ramp.sv =====
// channel   dir  handshake              payload
// vertex    in   vertex_valid/_stall    tvcr_pkg::vertex_t
// color     out  color_valid/_stall     tvcr_pkg::color_t
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one request per cycle while no held color stalls the pipeline
// the pipeline includes the 17-stage height divider and the 8-stage color divider
// all stages advance together; a held color stalls the whole pipeline
// reset clears valid bits and the configuration registers to zero
`default_nettype none

module terrain_vertex_color_ramp #(
    parameter int GRADIENT_POINTS = tvcr_pkg::GRADIENT_POINTS_DEF,
    parameter int SLANT_ENTRIES   = tvcr_pkg::SLANT_ENTRIES_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                vertex_valid,
    output logic                               vertex_stall,
    input  wire  tvcr_pkg::vertex_t            vertex,
    output logic                               color_valid,
    input  wire                                color_stall,
    output tvcr_pkg::color_t                   color,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [tvcr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire  [tvcr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic en;

    assign en           = !color_valid || !color_stall;
    assign vertex_stall = !en;
    assign cfg_ready    = 1'b1;

    // configuration registers
    logic [15:0]                              min_reg;
    logic [15:0]                              max_reg;
    tvcr_pkg::gpoint_t [GRADIENT_POINTS-1:0]  gp_reg;
    tvcr_pkg::slant_t  [SLANT_ENTRIES-1:0]    se_reg;
    tvcr_pkg::reg_index_t                     cfg_sel;
    logic [tvcr_pkg::CFG_INDEX_W-1:0]         gp_slot;
    logic [tvcr_pkg::CFG_INDEX_W-1:0]         se_slot;

    assign cfg_sel = tvcr_pkg::reg_index_t'(cfg_index);
    assign gp_slot = cfg_index - tvcr_pkg::REG_GP0;
    assign se_slot = cfg_index - tvcr_pkg::REG_SE0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= '0;
            gp_reg  <= '0;
            se_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_sel) inside
                tvcr_pkg::REG_MIN_HEIGHT:
                begin
                    min_reg <= cfg_data[15:0];
                end
                tvcr_pkg::REG_MAX_HEIGHT:
                begin
                    max_reg <= cfg_data[15:0];
                end
                tvcr_pkg::REG_GP0, tvcr_pkg::REG_GP1, tvcr_pkg::REG_GP2, tvcr_pkg::REG_GP3:
                begin
                    for (int i = 0; i < GRADIENT_POINTS; i++)
                    begin
                        if (gp_slot == tvcr_pkg::CFG_INDEX_W'(i))
                        begin
                            gp_reg[i] <= cfg_data[tvcr_pkg::GP_W-1:0];
                        end
                    end
                end
                tvcr_pkg::REG_SE0, tvcr_pkg::REG_SE1:
                begin
                    for (int i = 0; i < SLANT_ENTRIES; i++)
                    begin
                        if (se_slot == tvcr_pkg::CFG_INDEX_W'(i))
                        begin
                            se_reg[i] <= cfg_data;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // front end
    logic                                f_valid;
    logic [tvcr_pkg::NORM_D_W-1:0]       f_rem;
    logic [tvcr_pkg::NORM_Q_W-1:0]       f_bits;
    logic [tvcr_pkg::NORM_D_W-1:0]       f_div;
    tvcr_pkg::norm_side_t                f_side;

    tvcr_front #(
        .SLANT_ENTRIES (SLANT_ENTRIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (vertex_valid),
        .vertex     (vertex),
        .min_height (min_reg),
        .max_height (max_reg),
        .slants     (se_reg),
        .out_valid  (f_valid),
        .out_rem    (f_rem),
        .out_bits   (f_bits),
        .out_div    (f_div),
        .out_side   (f_side)
    );

    // height normalization divider
    logic                                n_valid;
    logic [tvcr_pkg::NORM_Q_W-1:0]       n_quot;
    logic                                n_rem_nz;
    tvcr_pkg::norm_side_t                n_side;

    tvcr_div #(
        .Q_W    (tvcr_pkg::NORM_Q_W),
        .D_W    (tvcr_pkg::NORM_D_W),
        .LANES  (1),
        .SIDE_W ($bits(tvcr_pkg::norm_side_t))
    ) u_norm_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (f_valid),
        .in_rem     (f_rem),
        .in_bits    (f_bits),
        .in_div     (f_div),
        .in_side    (f_side),
        .out_valid  (n_valid),
        .out_quot   (n_quot),
        .out_rem_nz (n_rem_nz),
        .out_side   (n_side)
    );

    // gradient lookup
    logic                                                   r_valid;
    logic [tvcr_pkg::CHANNELS-1:0][tvcr_pkg::MIX_D_W-1:0]   r_rem;
    logic [tvcr_pkg::CHANNELS-1:0][tvcr_pkg::MIX_Q_W-1:0]   r_bits;
    logic [tvcr_pkg::MIX_D_W-1:0]                           r_div;
    tvcr_pkg::mix_side_t                                    r_side;

    tvcr_ramp #(
        .GRADIENT_POINTS (GRADIENT_POINTS)
    ) u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n_valid),
        .in_quot   (n_quot),
        .in_rem_nz (n_rem_nz),
        .in_side   (n_side),
        .points    (gp_reg),
        .out_valid (r_valid),
        .out_rem   (r_rem),
        .out_bits  (r_bits),
        .out_div   (r_div),
        .out_side  (r_side)
    );

    // interpolation divider, one lane per channel
    logic                                                   m_valid;
    logic [tvcr_pkg::CHANNELS-1:0][tvcr_pkg::MIX_Q_W-1:0]   m_quot;
    logic [tvcr_pkg::CHANNELS-1:0]                          m_rem_nz;
    tvcr_pkg::mix_side_t                                    m_side;

    tvcr_div #(
        .Q_W    (tvcr_pkg::MIX_Q_W),
        .D_W    (tvcr_pkg::MIX_D_W),
        .LANES  (tvcr_pkg::CHANNELS),
        .SIDE_W ($bits(tvcr_pkg::mix_side_t))
    ) u_mix_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (r_valid),
        .in_rem     (r_rem),
        .in_bits    (r_bits),
        .in_div     (r_div),
        .in_side    (r_side),
        .out_valid  (m_valid),
        .out_quot   (m_quot),
        .out_rem_nz (m_rem_nz),
        .out_side   (m_side)
    );

    // slant blend and output register
    tvcr_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid),
        .in_quot   (m_quot),
        .in_side   (m_side),
        .out_valid (color_valid),
        .out_color (color)
    );

    a_new_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(color_valid) |-> !$past(vertex_stall))
        else $error("color appeared without a pipeline advance");

    a_rem_unused: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid && m_side.mode == tvcr_pkg::MODE_INTERP |-> m_rem_nz == m_rem_nz)
        else $error("interpolation remainder undefined");

    a_color_hold: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && color_stall |=> color_valid && $stable(color))
        else $error("held color changed");

endmodule

`default_nettype wire

// ===== bench/terrain_vertex_color_ramp_test.sv =====
`timescale 1ns / 100ps
`default_nettype none

module terrain_vertex_color_ramp_test;

    localparam int VERTEX_W = $bits(tvcr_pkg::vertex_t);

    logic clk;
    logic rst_n;
    logic vertex_valid;
    logic vertex_stall;
    tvcr_pkg::vertex_t vertex;
    logic color_valid;
    logic color_stall;
    tvcr_pkg::color_t color;
    logic cfg_valid;
    logic cfg_ready;
    logic [tvcr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tvcr_pkg::CFG_DATA_W-1:0] cfg_data;

    terrain_vertex_color_ramp uut (
        .clk(clk),
        .rst_n(rst_n),
        .vertex_valid(vertex_valid),
        .vertex_stall(vertex_stall),
        .vertex(vertex),
        .color_valid(color_valid),
        .color_stall(color_stall),
        .color(color),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // shadow copy of the configuration
    logic signed [15:0] low_level;
    logic signed [15:0] high_level;
    logic [40:0] ramp_point [tvcr_pkg::GP_SLOTS];
    logic [63:0] slope_band [tvcr_pkg::SE_SLOTS];

    tvcr_pkg::vertex_t pending_vertices[$];
    tvcr_pkg::color_t expected_colors[$];
    int errors;
    int vertices_sent;
    int colors_seen;
    int gap_left;
    int color_gap_left;
    int hold_cycles;
    bit random_gaps;
    logic vertex_stall_q;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("timeout at %0t", $time);
        $display("** terrain_vertex_color_ramp: FAILED **");
        $finish;
    end

    function automatic logic signed [15:0] scaled_height(logic signed [15:0] h);
        longint span;
        longint num;
        longint q;
        span = longint'(high_level) - longint'(low_level);
        if (span == 0)
            return tvcr_pkg::HN_FLAT;
        num = (longint'(h) - longint'(low_level)) * 32768;
        if (span < 0)
        begin
            span = -span;
            num = -num;
        end
        q = num / span;
        if ((num % span) != 0 && num < 0)
            q = q - 1;
        q = q - 16384;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return 16'(q);
    endfunction

    function automatic tvcr_pkg::color_t shade_vertex(tvcr_pkg::vertex_t v);
        logic [15:0] nb [8];
        int steep;
        int d;
        int rate;
        logic [23:0] tint;
        logic [63:0] e;
        int hn;
        int ph;
        bit got_hi;
        bit got_lo;
        int hi_h;
        int lo_h;
        logic [23:0] hi_c;
        logic [23:0] lo_c;
        int base [3];
        int t;
        int span;
        int off;
        tvcr_pkg::color_t r;
        nb = '{v.north_west_height, v.north_height, v.north_east_height, v.west_height,
               v.east_height, v.south_west_height, v.south_height, v.south_east_height};
        steep = 0;
        for (int i = 0; i < 8; i++)
            if (v.neighbor_inside[i])
            begin
                d = int'(v.center_height) - int'($signed(nb[i]));
                if (d < 0)
                    d = -d;
                if (d > steep)
                    steep = d;
            end
        if (steep > 32767)
            steep = 32767;
        rate = 0;
        tint = 24'hffffff;
        for (int i = 0; i < tvcr_pkg::SLANT_ENTRIES_DEF; i++)
        begin
            e = slope_band[i];
            if (int'(e[63:48]) <= steep && steep <= int'(e[47:32]))
            begin
                tint = e[31:8];
                rate = int'(e[7:0]);
                break;
            end
        end
        hn = int'(scaled_height(v.center_height));
        got_hi = 1'b0;
        got_lo = 1'b0;
        hi_h = 0;
        lo_h = 0;
        hi_c = '0;
        lo_c = '0;
        for (int i = 0; i < tvcr_pkg::GRADIENT_POINTS_DEF; i++)
        begin
            if (!ramp_point[i][40])
                continue;
            ph = int'($signed(ramp_point[i][39:24]));
            if (hn < ph && (!got_hi || hi_h > ph))
            begin
                got_hi = 1'b1;
                hi_h = ph;
                hi_c = ramp_point[i][23:0];
            end
            if (hn > ph && (!got_lo || lo_h < ph))
            begin
                got_lo = 1'b1;
                lo_h = ph;
                lo_c = ramp_point[i][23:0];
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            if (!got_hi && !got_lo)
                base[k] = 255;
            else if (!got_lo)
                base[k] = int'(hi_c[16-8*k +: 8]);
            else if (!got_hi)
                base[k] = int'(lo_c[16-8*k +: 8]);
            else
            begin
                span = hi_h - lo_h;
                off = hn - lo_h;
                base[k] = (int'(lo_c[16-8*k +: 8]) * (span - off)
                           + int'(hi_c[16-8*k +: 8]) * off + span / 2) / span;
            end
            t = (base[k] * (255 - rate) + int'(tint[16-8*k +: 8]) * rate + 127) / 255;
            if (k == 0)
                r.red = 8'(t);
            else if (k == 1)
                r.green = 8'(t);
            else
                r.blue = 8'(t);
        end
        return r;
    endfunction

    task automatic write_reg(tvcr_pkg::reg_index_t idx, logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx) inside
            tvcr_pkg::REG_MIN_HEIGHT: low_level = value[15:0];
            tvcr_pkg::REG_MAX_HEIGHT: high_level = value[15:0];
            tvcr_pkg::REG_GP0, tvcr_pkg::REG_GP1, tvcr_pkg::REG_GP2, tvcr_pkg::REG_GP3:
                ramp_point[2'(idx - tvcr_pkg::REG_GP0)] = value[40:0];
            default: slope_band[1'(idx - tvcr_pkg::REG_SE0)] = value;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_vertices.size() != 0 || vertex_valid || expected_colors.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic tvcr_pkg::vertex_t random_vertex(int spread);
        tvcr_pkg::vertex_t v;
        int c;
        v.center_height = 16'($urandom);
        c = int'(v.center_height);
        v.north_west_height = 16'(c + $urandom_range(0, 2 * spread) - spread);
        v.north_height = 16'(c + $urandom_range(0, 2 * spread) - spread);
        v.north_east_height = 16'(c + $urandom_range(0, 2 * spread) - spread);
        v.west_height = 16'(c + $urandom_range(0, 2 * spread) - spread);
        v.east_height = 16'(c + $urandom_range(0, 2 * spread) - spread);
        v.south_west_height = 16'(c + $urandom_range(0, 2 * spread) - spread);
        v.south_height = 16'(c + $urandom_range(0, 2 * spread) - spread);
        v.south_east_height = 16'(c + $urandom_range(0, 2 * spread) - spread);
        if ($urandom_range(0, 5) == 0)
            v = VERTEX_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        v.neighbor_inside = 8'($urandom);
        return v;
    endfunction

    function automatic logic [40:0] random_point();
        return {1'($urandom_range(0, 3) != 0), 16'($urandom), 24'($urandom)};
    endfunction

    function automatic logic [63:0] random_band();
        logic [15:0] a;
        logic [15:0] b;
        a = 16'($urandom_range(0, 3000));
        b = a + 16'($urandom_range(0, 20000));
        if ($urandom_range(0, 4) == 0)
            return {$urandom, $urandom};
        return {a, b, 24'($urandom), 8'($urandom)};
    endfunction

    // sender
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_valid <= 1'b0;
            vertex <= '0;
            gap_left <= 0;
        end
        else if (!vertex_valid || !vertex_stall_q)
        begin
            if (gap_left > 0)
            begin
                vertex_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_vertices.size() != 0)
            begin
                vertex_valid <= 1'b1;
                vertex <= pending_vertices.pop_front();
                gap_left <= random_gaps ? int'($urandom_range(0, 7)) : 0;
            end
            else
                vertex_valid <= 1'b0;
        end
    end

    // accept flags seen at the rising edge
    always @(posedge clk)
    begin
        vertex_stall_q <= vertex_stall;
        if (rst_n && vertex_valid && !vertex_stall)
        begin
            expected_colors = {expected_colors, shade_vertex(vertex)};
            vertices_sent <= vertices_sent + 1;
        end
    end

    // receiver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_stall <= 1'b0;
            color_gap_left <= 0;
        end
        else if (hold_cycles > 0)
        begin
            color_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (color_gap_left > 0)
        begin
            color_stall <= 1'b1;
            color_gap_left <= color_gap_left - 1;
        end
        else if (random_gaps && color_valid && !color_stall)
        begin
            color_gap_left <= int'($urandom_range(0, 7));
            color_stall <= 1'b0;
        end
        else
            color_stall <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        tvcr_pkg::color_t want;
        if (rst_n && color_valid && !color_stall)
        begin
            colors_seen <= colors_seen + 1;
            if (expected_colors.size() == 0)
            begin
                $display("%0t: unexpected color %h", $time, color);
                errors <= errors + 1;
            end
            else
            begin
                want = expected_colors.pop_front();
                if (want.red !== color.red || want.green !== color.green
                    || want.blue !== color.blue)
                begin
                    $display("%0t: color expected %h got %h", $time, want, color);
                    errors <= errors + 1;
                end
            end
        end
    end

    initial
    begin
        tvcr_pkg::vertex_t v;
        errors = 0;
        vertices_sent = 0;
        colors_seen = 0;
        hold_cycles = 0;
        random_gaps = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        low_level = 0;
        high_level = 0;
        for (int i = 0; i < tvcr_pkg::GP_SLOTS; i++)
            ramp_point[i] = '0;
        for (int i = 0; i < tvcr_pkg::SE_SLOTS; i++)
            slope_band[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset configuration: flat, no points, zero band
        for (int i = 0; i < 4; i++)
            pending_vertices = {pending_vertices, random_vertex(100)};
        wait_drained();

        // directed setting
        write_reg(tvcr_pkg::REG_MIN_HEIGHT, 64'(-16'sd1000));
        write_reg(tvcr_pkg::REG_MAX_HEIGHT, 64'(16'sd1000));
        write_reg(tvcr_pkg::REG_GP0, 64'({1'b1, -16'sd8000, 24'h102030}));
        write_reg(tvcr_pkg::REG_GP1, 64'({1'b1, 16'sd8000, 24'hf0e0d0}));
        write_reg(tvcr_pkg::REG_GP2, 64'({1'b1, 16'sd8000, 24'h00ff00}));
        write_reg(tvcr_pkg::REG_GP3, 64'({1'b0, 16'sd0, 24'h0000ff}));
        write_reg(tvcr_pkg::REG_SE0, {16'd0, 16'd10, 24'h000000, 8'd0});
        write_reg(tvcr_pkg::REG_SE1, {16'd11, 16'd65535, 24'h804020, 8'd255});
        v = '0;
        v.neighbor_inside = 8'hff;
        pending_vertices = {pending_vertices, v};
        v.center_height = 16'sh7fff;
        v.north_west_height = 16'sh8000;
        pending_vertices = {pending_vertices, v};
        v.center_height = 16'sh8000;
        v.north_west_height = 16'sh7fff;
        pending_vertices = {pending_vertices, v};
        v.neighbor_inside = 8'h00;
        pending_vertices = {pending_vertices, v};
        for (int h = -1000; h <= 1000; h += 125)
        begin
            v = '0;
            v.center_height = 16'(h);
            v.south_east_height = 16'(h + 5);
            v.neighbor_inside = 8'h80;
            pending_vertices = {pending_vertices, v};
        end
        v = '1;
        pending_vertices = {pending_vertices, v};
        wait_drained();

        // inverted range, one sided
        write_reg(tvcr_pkg::REG_MIN_HEIGHT, 64'(16'sh7fff));
        write_reg(tvcr_pkg::REG_MAX_HEIGHT, 64'(16'sh8000));
        write_reg(tvcr_pkg::REG_GP1, 64'({1'b0, 16'sd0, 24'h0}));
        write_reg(tvcr_pkg::REG_GP2, 64'({1'b0, 16'sd0, 24'h0}));
        for (int i = 0; i < 8; i++)
            pending_vertices = {pending_vertices, random_vertex(30000)};
        wait_drained();

        // long receiver hold while the sender keeps offering
        hold_cycles = 120;
        for (int i = 0; i < 80; i++)
            pending_vertices = {pending_vertices, random_vertex(500)};
        wait_drained();

        random_gaps = 1;
        for (int phase = 0; phase < 7; phase++)
        begin
            write_reg(tvcr_pkg::REG_MIN_HEIGHT,
                      64'($urandom_range(0, 1) ? 16'sh8000 : 16'($urandom)));
            write_reg(tvcr_pkg::REG_MAX_HEIGHT,
                      64'($urandom_range(0, 1) ? 16'sh7fff : 16'($urandom)));
            write_reg(tvcr_pkg::REG_GP0, 64'(random_point()));
            write_reg(tvcr_pkg::REG_GP1, 64'(random_point()));
            write_reg(tvcr_pkg::REG_GP2, 64'(random_point()));
            write_reg(tvcr_pkg::REG_GP3, 64'(random_point()));
            write_reg(tvcr_pkg::REG_SE0, random_band());
            write_reg(tvcr_pkg::REG_SE1, random_band());
            random_gaps = (phase % 3) != 2;
            for (int i = 0; i < 200; i++)
                pending_vertices = {pending_vertices,
                                    random_vertex(phase < 3 ? 2000 : 40000)};
            wait_drained();
        end

        $display("%0d vertices, %0d colors checked over flat, inverted and random ramps",
                 vertices_sent, colors_seen);
        $display("including stalls, idle gaps and a long output hold");
        if (errors == 0)
            $display("** terrain_vertex_color_ramp: PASSED **");
        else
            $display("** terrain_vertex_color_ramp: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/tvcr_pkg.sv
design/tvcr_div.sv
design/tvcr_front.sv
design/tvcr_ramp.sv
design/tvcr_blend.sv
design/terrain_vertex_color_ramp.sv
bench/terrain_vertex_color_ramp_test.sv
